>>> hdl/lpct_pkg.sv
`timescale 1ns / 1ps
package lpct_pkg;

  localparam int COORD_W = 12;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int C_W     = PROD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DEN_W   = 2 * DIFF_W + 1;
  localparam int DOT_W   = 2 * DIFF_W + 1;
  localparam int LEN_W   = 2 * COORD_W + 1;
  localparam int LAB_W   = 2 * LEN_W;
  localparam int DSQ_W   = 2 * (DOT_W - 2);
  localparam int PRD_W   = C_W + DIFF_W;
  localparam int NUM_W   = PRD_W + 1;
  localparam int TOL_W   = 16;
  localparam int HALF_W  = LAB_W / 2;
  localparam int TP_W    = HALF_W + TOL_W;
  localparam int CMP_W   = DSQ_W + TOL_W;
  localparam int DIM_W   = 13;
  localparam int OUT_W   = 16;
  localparam int QBITS   = OUT_W + 1;
  localparam int REM_W   = DEN_W;
  localparam int TOP_W   = NUM_W - QBITS;
  localparam int BIG_W   = REM_W + QBITS;
  localparam int QM_W    = QBITS + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd4096;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd4096;
  localparam logic [TOL_W-1:0] TOL_RST    = 16'd180;

  localparam int FRONT_STAGES = 7;
  localparam int LATENCY      = FRONT_STAGES + QBITS + 2;

  typedef struct packed {
    logic [COORD_W-1:0] a_start_x;
    logic [COORD_W-1:0] a_start_y;
    logic [COORD_W-1:0] a_end_x;
    logic [COORD_W-1:0] a_end_y;
    logic [COORD_W-1:0] b_start_x;
    logic [COORD_W-1:0] b_start_y;
    logic [COORD_W-1:0] b_end_x;
    logic [COORD_W-1:0] b_end_y;
  } lpct_in_t;

  typedef struct packed {
    logic                    is_parallel;
    logic signed [OUT_W-1:0] cross_x;
    logic signed [OUT_W-1:0] cross_y;
    logic                    inside_image;
    logic                    near_right_angle;
    logic                    corner_found;
  } lpct_out_t;

  typedef struct packed {
    logic             par;
    logic             perp;
    logic             sx;
    logic             sy;
    logic             bigx;
    logic             bigy;
    logic [REM_W-1:0] d;
    logic [REM_W-1:0] remx;
    logic [REM_W-1:0] remy;
    logic [QBITS-1:0] nbx;
    logic [QBITS-1:0] nby;
    logic [QBITS-1:0] qx;
    logic [QBITS-1:0] qy;
  } lpct_cell_t;

endpackage

>>> hdl/line_pair_corner_test_unit.sv
`timescale 1ns / 1ps
// Channel  | Ports                                 | Handshake
// ---------+---------------------------------------+-------------------------------
// input    | start, busy, in_item                  | taken when start and not busy
// result   | out_valid, out_result                 | one-cycle strobe, no back pressure
// config   | cfg_we, cfg_index, cfg_data           | written on any edge with cfg_we
//
// The block takes one item per cycle and busy stays low. Each result passes
// through seven arithmetic stages, one division cell per quotient bit
// (seventeen), a rounding stage and the output register.
// Reset is synchronous and active low; it clears the pipeline valid bits and
// loads the register defaults. The receiver cannot stall, so nothing ever waits.
module line_pair_corner_test_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  lpct_pkg::lpct_in_t              in_item,
  output logic                            out_valid,
  output lpct_pkg::lpct_out_t             out_result,
  input  logic                            cfg_we,
  input  logic [lpct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lpct_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  logic [TOL_W-1:0] tol_r;
  logic             accept;

  // Division chain: entry 0 is the front end output, entry k+1 the output
  // of cell k. Each cell resolves one quotient bit of both coordinates.
  lpct_cell_t       chain [0:QBITS];
  logic [QBITS:0]   chain_v;

  // The pipeline never holds an item back.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      tol_r    <= TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        REG_TOL:    tol_r    <= cfg_data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lpct_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (accept),
    .item_i  (in_item),
    .tol_i   (tol_r),
    .valid_o (chain_v[0]),
    .cell_o  (chain[0])
  );

  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    lpct_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (chain_v[k]),
      .cell_i  (chain[k]),
      .valid_o (chain_v[k+1]),
      .cell_o  (chain[k+1])
    );
  end

  lpct_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (chain_v[QBITS]),
    .cell_i   (chain[QBITS]),
    .width_i  (width_r),
    .height_i (height_r),
    .valid_o  (out_valid),
    .result_o (out_result)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without a matching item");
  a_chain_flow: assert property (@(posedge clk) disable iff (!rst_n)
    chain_v[QBITS] |-> $past(chain_v[0], QBITS))
    else $error("division chain lost step");
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("item refused");
`endif

endmodule

>>> hdl/lpct_cell.sv
`timescale 1ns / 1ps
module lpct_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  lpct_pkg::lpct_cell_t cell_i,
  output logic                valid_o,
  output lpct_pkg::lpct_cell_t cell_o
);
  import lpct_pkg::*;

  // One restoring division step for both coordinates against the same divisor.
  logic [REM_W:0] tx, ty, dd;
  logic           gex, gey;
  logic           valid_r;
  lpct_cell_t     cell_r, cell_nxt;

  always_comb begin
    dd  = {1'b0, cell_i.d};
    tx  = {cell_i.remx, cell_i.nbx[QBITS-1]};
    ty  = {cell_i.remy, cell_i.nby[QBITS-1]};
    gex = (tx >= dd);
    gey = (ty >= dd);
    cell_nxt      = cell_i;
    cell_nxt.remx = gex ? REM_W'(tx - dd) : tx[REM_W-1:0];
    cell_nxt.remy = gey ? REM_W'(ty - dd) : ty[REM_W-1:0];
    cell_nxt.nbx  = {cell_i.nbx[QBITS-2:0], 1'b0};
    cell_nxt.nby  = {cell_i.nby[QBITS-2:0], 1'b0};
    cell_nxt.qx   = {cell_i.qx[QBITS-2:0], gex};
    cell_nxt.qy   = {cell_i.qy[QBITS-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign valid_o = valid_r;
  assign cell_o  = cell_r;

endmodule

>>> hdl/lpct_front.sv
`timescale 1ns / 1ps
module lpct_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  lpct_pkg::lpct_in_t            item_i,
  input  logic [lpct_pkg::TOL_W-1:0]    tol_i,
  output logic                          valid_o,
  output lpct_pkg::lpct_cell_t          cell_o
);
  import lpct_pkg::*;

  logic [FRONT_STAGES-1:0] v_r;

  // Stage 1: coordinate differences and zero-length fixup.
  logic [COORD_W-1:0]      s1_x1_r, s1_y1_r, s1_x2_r, s1_y2_r;
  logic [COORD_W-1:0]      s1_x3_r, s1_y3_r, s1_x4_r, s1_y4_r;
  logic signed [DIFF_W-1:0] s1_dxa_r, s1_dya_r, s1_dxb_r, s1_dyb_r;
  logic signed [DIFF_W-1:0] s1_fxa_r, s1_fxb_r;
  logic signed [DIFF_W-1:0] dxa, dya, dxb, dyb;

  // Stage 2: products.
  logic [PROD_W-1:0]        s2_c1a_r, s2_c1b_r, s2_c2a_r, s2_c2b_r;
  logic signed [SQ_W-1:0]   s2_da_r, s2_db_r, s2_pxx_r, s2_pyy_r;
  logic signed [SQ_W-1:0]   s2_sxa_r, s2_sya_r, s2_sxb_r, s2_syb_r;
  logic signed [DIFF_W-1:0] s2_dxa_r, s2_dya_r, s2_dxb_r, s2_dyb_r;

  // Stage 3: sums.
  logic signed [C_W-1:0]    s3_c1_r, s3_c2_r;
  logic signed [DEN_W-1:0]  s3_den_r;
  logic signed [DOT_W-1:0]  s3_dot_r;
  logic [LEN_W-1:0]         s3_la2_r, s3_lb2_r;
  logic signed [DIFF_W-1:0] s3_dxa_r, s3_dya_r, s3_dxb_r, s3_dyb_r;

  // Stage 4: numerator terms, dot squared, length product.
  logic signed [PRD_W-1:0]   s4_p1_r, s4_p2_r, s4_p3_r, s4_p4_r;
  logic signed [2*DOT_W-1:0] dsq_full;
  logic [DSQ_W-1:0]          s4_dsq_r;
  logic [LAB_W-1:0]          s4_lab_r;
  logic signed [DEN_W-1:0]   s4_den_r;

  // Stage 5: numerators and tolerance partial products.
  logic signed [NUM_W-1:0] s5_nx_r, s5_ny_r;
  logic [TP_W-1:0]         s5_tlo_r, s5_thi_r;
  logic [DSQ_W-1:0]        s5_dsq_r;
  logic signed [DEN_W-1:0] s5_den_r;

  // Stage 6: magnitudes, signs and the angle compare.
  logic [NUM_W-1:0] s6_nx_r, s6_ny_r;
  logic [REM_W-1:0] s6_d_r;
  logic             s6_sx_r, s6_sy_r, s6_par_r, s6_perp_r;
  logic [CMP_W-1:0] rhs, lhs;

  // Stage 7: overflow check and division setup.
  lpct_cell_t       s7_r;
  logic [BIG_W-1:0] dshift;

  always_comb begin
    dxa = $signed({1'b0, item_i.a_start_x}) - $signed({1'b0, item_i.a_end_x});
    dya = $signed({1'b0, item_i.a_start_y}) - $signed({1'b0, item_i.a_end_y});
    dxb = $signed({1'b0, item_i.b_start_x}) - $signed({1'b0, item_i.b_end_x});
    dyb = $signed({1'b0, item_i.b_start_y}) - $signed({1'b0, item_i.b_end_y});
    dsq_full = s3_dot_r * s3_dot_r;
    rhs    = {s5_thi_r, {HALF_W{1'b0}}} + CMP_W'(s5_tlo_r);
    lhs    = {s5_dsq_r, {TOL_W{1'b0}}};
    dshift = {s6_d_r, {QBITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[FRONT_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    s1_x1_r  <= item_i.a_start_x;
    s1_y1_r  <= item_i.a_start_y;
    s1_x2_r  <= item_i.a_end_x;
    s1_y2_r  <= item_i.a_end_y;
    s1_x3_r  <= item_i.b_start_x;
    s1_y3_r  <= item_i.b_start_y;
    s1_x4_r  <= item_i.b_end_x;
    s1_y4_r  <= item_i.b_end_y;
    s1_dxa_r <= dxa;
    s1_dya_r <= dya;
    s1_dxb_r <= dxb;
    s1_dyb_r <= dyb;
    // A zero-length segment points along +x; the fixup of -1 matches the
    // start-minus-end sign convention of these differences.
    s1_fxa_r <= (dxa == '0 && dya == '0) ? {DIFF_W{1'b1}} : dxa;
    s1_fxb_r <= (dxb == '0 && dyb == '0) ? {DIFF_W{1'b1}} : dxb;

    s2_c1a_r <= s1_x1_r * s1_y2_r;
    s2_c1b_r <= s1_y1_r * s1_x2_r;
    s2_c2a_r <= s1_x3_r * s1_y4_r;
    s2_c2b_r <= s1_y3_r * s1_x4_r;
    s2_da_r  <= s1_dxa_r * s1_dyb_r;
    s2_db_r  <= s1_dya_r * s1_dxb_r;
    s2_pxx_r <= s1_fxa_r * s1_fxb_r;
    s2_pyy_r <= s1_dya_r * s1_dyb_r;
    s2_sxa_r <= s1_fxa_r * s1_fxa_r;
    s2_sya_r <= s1_dya_r * s1_dya_r;
    s2_sxb_r <= s1_fxb_r * s1_fxb_r;
    s2_syb_r <= s1_dyb_r * s1_dyb_r;
    s2_dxa_r <= s1_dxa_r;
    s2_dya_r <= s1_dya_r;
    s2_dxb_r <= s1_dxb_r;
    s2_dyb_r <= s1_dyb_r;

    s3_c1_r  <= $signed({1'b0, s2_c1a_r}) - $signed({1'b0, s2_c1b_r});
    s3_c2_r  <= $signed({1'b0, s2_c2a_r}) - $signed({1'b0, s2_c2b_r});
    s3_den_r <= DEN_W'(s2_da_r) - DEN_W'(s2_db_r);
    s3_dot_r <= DOT_W'(s2_pxx_r) + DOT_W'(s2_pyy_r);
    s3_la2_r <= LEN_W'(s2_sxa_r[LEN_W-2:0]) + LEN_W'(s2_sya_r[LEN_W-2:0]);
    s3_lb2_r <= LEN_W'(s2_sxb_r[LEN_W-2:0]) + LEN_W'(s2_syb_r[LEN_W-2:0]);
    s3_dxa_r <= s2_dxa_r;
    s3_dya_r <= s2_dya_r;
    s3_dxb_r <= s2_dxb_r;
    s3_dyb_r <= s2_dyb_r;

    s4_p1_r  <= s3_c1_r * s3_dxb_r;
    s4_p2_r  <= s3_dxa_r * s3_c2_r;
    s4_p3_r  <= s3_c1_r * s3_dyb_r;
    s4_p4_r  <= s3_dya_r * s3_c2_r;
    s4_dsq_r <= dsq_full[DSQ_W-1:0];
    s4_lab_r <= s3_la2_r * s3_lb2_r;
    s4_den_r <= s3_den_r;

    s5_nx_r  <= NUM_W'(s4_p1_r) - NUM_W'(s4_p2_r);
    s5_ny_r  <= NUM_W'(s4_p3_r) - NUM_W'(s4_p4_r);
    s5_tlo_r <= s4_lab_r[HALF_W-1:0] * tol_i;
    s5_thi_r <= s4_lab_r[LAB_W-1:HALF_W] * tol_i;
    s5_dsq_r <= s4_dsq_r;
    s5_den_r <= s4_den_r;

    s6_nx_r   <= s5_nx_r[NUM_W-1] ? NUM_W'(-s5_nx_r) : s5_nx_r;
    s6_ny_r   <= s5_ny_r[NUM_W-1] ? NUM_W'(-s5_ny_r) : s5_ny_r;
    s6_d_r    <= s5_den_r[DEN_W-1] ? REM_W'(-s5_den_r) : s5_den_r;
    s6_sx_r   <= s5_nx_r[NUM_W-1] ^ s5_den_r[DEN_W-1];
    s6_sy_r   <= s5_ny_r[NUM_W-1] ^ s5_den_r[DEN_W-1];
    s6_par_r  <= (s5_den_r == '0);
    s6_perp_r <= (lhs <= rhs);

    s7_r.par  <= s6_par_r;
    s7_r.perp <= s6_perp_r;
    s7_r.sx   <= s6_sx_r;
    s7_r.sy   <= s6_sy_r;
    // A quotient of 2^17 or more saturates whatever the rounding does.
    s7_r.bigx <= (BIG_W'(s6_nx_r) >= dshift);
    s7_r.bigy <= (BIG_W'(s6_ny_r) >= dshift);
    s7_r.d    <= s6_d_r;
    s7_r.remx <= REM_W'(s6_nx_r[NUM_W-1:QBITS]);
    s7_r.remy <= REM_W'(s6_ny_r[NUM_W-1:QBITS]);
    s7_r.nbx  <= s6_nx_r[QBITS-1:0];
    s7_r.nby  <= s6_ny_r[QBITS-1:0];
    s7_r.qx   <= '0;
    s7_r.qy   <= '0;
  end

  assign valid_o = v_r[FRONT_STAGES-1];
  assign cell_o  = s7_r;

endmodule

>>> hdl/lpct_back.sv
`timescale 1ns / 1ps
module lpct_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  input  lpct_pkg::lpct_cell_t       cell_i,
  input  logic [lpct_pkg::DIM_W-1:0] width_i,
  input  logic [lpct_pkg::DIM_W-1:0] height_i,
  output logic                       valid_o,
  output lpct_pkg::lpct_out_t        result_o
);
  import lpct_pkg::*;

  function automatic logic signed [OUT_W-1:0] sat_val(
    input logic big, input logic neg, input logic [QM_W-1:0] qm);
    logic signed [OUT_W-1:0] r;
    logic                    ovf;
    ovf = big || qm[QM_W-1] || qm[QM_W-2] || qm[OUT_W-1];
    if (neg) begin
      r = ovf ? {1'b1, {(OUT_W-1){1'b0}}} : -$signed(qm[OUT_W-1:0]);
    end else begin
      r = ovf ? {1'b0, {(OUT_W-1){1'b1}}} : $signed(qm[OUT_W-1:0]);
    end
    return r;
  endfunction

  logic [REM_W:0]          dd, r2x, r2y;
  logic                    incx, incy;
  logic                    f1_v_r, f2_v_r;
  logic [QM_W-1:0]         f1_qx_r, f1_qy_r;
  logic                    f1_bigx_r, f1_bigy_r, f1_sx_r, f1_sy_r, f1_par_r, f1_perp_r;
  logic signed [OUT_W-1:0] px, py;
  logic                    in_image;
  lpct_out_t               res_r;

  always_comb begin
    dd   = {1'b0, cell_i.d};
    r2x  = {cell_i.remx, 1'b0};
    r2y  = {cell_i.remy, 1'b0};
    // Round half to even on the magnitude; the rule is symmetric in sign.
    incx = (r2x > dd) || (r2x == dd && cell_i.qx[0]);
    incy = (r2y > dd) || (r2y == dd && cell_i.qy[0]);
    px = f1_par_r ? '0 : sat_val(f1_bigx_r, f1_sx_r, f1_qx_r);
    py = f1_par_r ? '0 : sat_val(f1_bigy_r, f1_sy_r, f1_qy_r);
    in_image = !f1_par_r && !px[OUT_W-1] && !py[OUT_W-1] &&
               (px < $signed({{(OUT_W-DIM_W){1'b0}}, width_i})) &&
               (py < $signed({{(OUT_W-DIM_W){1'b0}}, height_i}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      f1_v_r <= valid_i;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_qx_r   <= {1'b0, cell_i.qx} + QM_W'(incx);
    f1_qy_r   <= {1'b0, cell_i.qy} + QM_W'(incy);
    f1_bigx_r <= cell_i.bigx;
    f1_bigy_r <= cell_i.bigy;
    f1_sx_r   <= cell_i.sx;
    f1_sy_r   <= cell_i.sy;
    f1_par_r  <= cell_i.par;
    f1_perp_r <= cell_i.perp;

    res_r.is_parallel      <= f1_par_r;
    res_r.cross_x          <= px;
    res_r.cross_y          <= py;
    res_r.inside_image     <= in_image;
    res_r.near_right_angle <= f1_perp_r;
    res_r.corner_found     <= in_image && f1_perp_r;
  end

  assign valid_o  = f2_v_r;
  assign result_o = res_r;

`ifndef ASSERT_OFF
  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    f2_v_r && res_r.is_parallel |->
      res_r.cross_x == '0 && res_r.cross_y == '0 && !res_r.inside_image)
    else $error("parallel item carries a nonzero point");
  a_corner: assert property (@(posedge clk) disable iff (!rst_n)
    f2_v_r && res_r.corner_found |->
      res_r.inside_image && res_r.near_right_angle && !res_r.is_parallel)
    else $error("corner flag disagrees with its parts");
  a_inside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    f2_v_r && res_r.inside_image |->
      !res_r.cross_x[OUT_W-1] && !res_r.cross_y[OUT_W-1])
    else $error("negative point marked inside");
`endif

endmodule
